[rtl/tle_pkg.sv]
// Shared types, constants and helpers for the text layout extent estimator.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package tle_pkg;

    localparam int GLYPH_BITS = 8;
    localparam int CUR_BITS   = 18;
    localparam int CALC_BITS  = 20;
    localparam int EXT_BITS   = 16;
    localparam int COORD_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    // Item operation codes
    localparam logic [1:0] OP_GLYPH  = 2'd0;
    localparam logic [1:0] OP_LF     = 2'd1;
    localparam logic [1:0] OP_CR     = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Configuration register indices
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTICAL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y    = 3'd4;

    localparam logic signed [COORD_BITS-1:0] END_RESET = 16'sh7FFF;

    localparam logic signed [CALC_BITS-1:0] CUR_MAX = 20'sh1FFFF;
    localparam logic signed [CALC_BITS-1:0] CUR_MIN = 20'shE0000;
    localparam logic signed [CALC_BITS-1:0] EXT_MAX = 20'sh0FFFF;

    typedef logic [GLYPH_BITS-1:0] glyph_t;

    typedef struct packed {
        logic                          vertical;
        logic signed [COORD_BITS-1:0]  origin_x;
        logic signed [COORD_BITS-1:0]  origin_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic                          load_x;
        logic                          load_y;
        logic signed [COORD_BITS-1:0]  load_data;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        glyph_t     w;
        glyph_t     h;
    } item_t;

    typedef struct packed {
        logic [EXT_BITS-1:0] est_width;
        logic [EXT_BITS-1:0] est_height;
        logic                stopped;
    } result_t;

    // Clamp a working value to the cursor range
    function automatic logic signed [CUR_BITS-1:0] sat_cursor(
        input logic signed [CALC_BITS-1:0] v
    );
        logic signed [CUR_BITS-1:0] r;
        if (v > CUR_MAX)
            r = CUR_MAX[CUR_BITS-1:0];
        else if (v < CUR_MIN)
            r = CUR_MIN[CUR_BITS-1:0];
        else
            r = v[CUR_BITS-1:0];
        return r;
    endfunction

    // Keep the larger of the recorded extent and a new reach, saturating
    function automatic logic [EXT_BITS-1:0] grow_extent(
        input logic [EXT_BITS-1:0]         ext,
        input logic signed [CALC_BITS-1:0] reach
    );
        logic [EXT_BITS-1:0] g;
        if (reach > $signed({{(CALC_BITS-EXT_BITS){1'b0}}, ext})) begin
            if (reach > EXT_MAX)
                g = EXT_MAX[EXT_BITS-1:0];
            else
                g = reach[EXT_BITS-1:0];
        end
        else
            g = ext;
        return g;
    endfunction

    function automatic logic signed [CALC_BITS-1:0] ext_cur(
        input logic signed [CUR_BITS-1:0] v
    );
        return {{(CALC_BITS-CUR_BITS){v[CUR_BITS-1]}}, v};
    endfunction

    function automatic logic signed [CALC_BITS-1:0] ext_coord(
        input logic signed [COORD_BITS-1:0] v
    );
        return {{(CALC_BITS-COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    function automatic logic signed [CALC_BITS-1:0] ext_glyph(input glyph_t v);
        return {{(CALC_BITS-GLYPH_BITS){1'b0}}, v};
    endfunction

endpackage

[rtl/tle_cfg.sv]
// Configuration register file for the text layout extent estimator.
// Depends on tle_pkg for the register indices and the cfg_t bundle.
module tle_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tle_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tle_pkg::COORD_BITS-1:0]    cfg_data,
    output tle_pkg::cfg_t                     cfg
);

    logic                                   vertical_reg;
    logic signed [tle_pkg::COORD_BITS-1:0]  origin_x_reg;
    logic signed [tle_pkg::COORD_BITS-1:0]  origin_y_reg;
    logic signed [tle_pkg::COORD_BITS-1:0]  end_x_reg;
    logic signed [tle_pkg::COORD_BITS-1:0]  end_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertical_reg <= 1'b0;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            end_x_reg    <= tle_pkg::END_RESET;
            end_y_reg    <= tle_pkg::END_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tle_pkg::REG_VERTICAL: vertical_reg <= cfg_data[0];
                tle_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                tle_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                tle_pkg::REG_END_X:    end_x_reg    <= cfg_data;
                tle_pkg::REG_END_Y:    end_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Origin writes also reload the matching cursor in the core
    always_comb
    begin
        cfg.vertical  = vertical_reg;
        cfg.origin_x  = origin_x_reg;
        cfg.origin_y  = origin_y_reg;
        cfg.end_x     = end_x_reg;
        cfg.end_y     = end_y_reg;
        cfg.load_x    = cfg_we && (cfg_index == tle_pkg::REG_ORIGIN_X);
        cfg.load_y    = cfg_we && (cfg_index == tle_pkg::REG_ORIGIN_Y);
        cfg.load_data = cfg_data;
    end

endmodule

[rtl/tle_core.sv]
// Layout state and its combinational next-state update: cursor, line extent, bounding box, halt flag.
// Depends on tle_pkg for item/result/config types and the saturating helpers.
module tle_core (
    input  logic              clk,
    input  logic              rst_n,
    input  tle_pkg::cfg_t     cfg,
    input  logic              step,
    input  tle_pkg::item_t    item,
    output tle_pkg::result_t  result
);

    logic signed [tle_pkg::CUR_BITS-1:0]  cursor_x_reg, cursor_x_next;
    logic signed [tle_pkg::CUR_BITS-1:0]  cursor_y_reg, cursor_y_next;
    tle_pkg::glyph_t                      line_ext_reg, line_ext_next;
    logic [tle_pkg::EXT_BITS-1:0]         ext_w_reg, ext_w_next;
    logic [tle_pkg::EXT_BITS-1:0]         ext_h_reg, ext_h_next;
    logic                                 halted_reg, halted_next;

    logic                                 vert;
    logic signed [tle_pkg::CALC_BITS-1:0] cx, cy, adv, lin;
    logic signed [tle_pkg::CALC_BITS-1:0] adv_size, lin_size, adv_end, lin_end, adv_org;
    logic signed [tle_pkg::CALC_BITS-1:0] le, gw, gh, lin1_w, cx1, cy1;
    logic signed [tle_pkg::CALC_BITS-1:0] reach_w, reach_h;
    logic signed [tle_pkg::CUR_BITS-1:0]  adv1, lin1, adv2, lf_lin, cr_adv;
    logic signed [tle_pkg::CUR_BITS-1:0]  org_x_cur, org_y_cur, load_cur;
    tle_pkg::glyph_t                      le1, le2, lin_size_g;
    logic                                 wrap, over;

    // Glyph placement datapath
    always_comb
    begin
        vert     = cfg.vertical;
        cx       = tle_pkg::ext_cur(cursor_x_reg);
        cy       = tle_pkg::ext_cur(cursor_y_reg);
        gw       = tle_pkg::ext_glyph(item.w);
        gh       = tle_pkg::ext_glyph(item.h);
        le       = tle_pkg::ext_glyph(line_ext_reg);
        adv      = vert ? cy : cx;
        lin      = vert ? cx : cy;
        adv_size = vert ? gh : gw;
        lin_size = vert ? gw : gh;
        lin_size_g = vert ? item.w : item.h;
        adv_end  = tle_pkg::ext_coord(vert ? cfg.end_y : cfg.end_x);
        lin_end  = tle_pkg::ext_coord(vert ? cfg.end_x : cfg.end_y);
        adv_org  = tle_pkg::ext_coord(vert ? cfg.origin_y : cfg.origin_x);

        // Wrap to a new line when the glyph would pass the advance edge
        wrap   = (adv + adv_size) > adv_end;
        lf_lin = tle_pkg::sat_cursor(lin + le);
        adv1   = wrap ? adv_org[tle_pkg::CUR_BITS-1:0] : adv[tle_pkg::CUR_BITS-1:0];
        lin1   = wrap ? lf_lin : lin[tle_pkg::CUR_BITS-1:0];
        le1    = wrap ? '0 : line_ext_reg;
        lin1_w = tle_pkg::ext_cur(lin1);

        over = (lin1_w + lin_size) > lin_end;
        le2  = (le1 < lin_size_g) ? lin_size_g : le1;

        cx1 = vert ? lin1_w : tle_pkg::ext_cur(adv1);
        cy1 = vert ? tle_pkg::ext_cur(adv1) : lin1_w;
        reach_w = cx1 + gw - tle_pkg::ext_coord(cfg.origin_x);
        reach_h = cy1 + gh - tle_pkg::ext_coord(cfg.origin_y);
        adv2 = tle_pkg::sat_cursor(tle_pkg::ext_cur(adv1) + adv_size);

        cr_adv = adv_org[tle_pkg::CUR_BITS-1:0];

        org_x_cur = {{(tle_pkg::CUR_BITS-tle_pkg::COORD_BITS){cfg.origin_x[tle_pkg::COORD_BITS-1]}},
                     cfg.origin_x};
        org_y_cur = {{(tle_pkg::CUR_BITS-tle_pkg::COORD_BITS){cfg.origin_y[tle_pkg::COORD_BITS-1]}},
                     cfg.origin_y};
        load_cur  = {{(tle_pkg::CUR_BITS-tle_pkg::COORD_BITS){cfg.load_data[tle_pkg::COORD_BITS-1]}},
                     cfg.load_data};
    end

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        line_ext_next = line_ext_reg;
        ext_w_next    = ext_w_reg;
        ext_h_next    = ext_h_reg;
        halted_next   = halted_reg;

        if (step)
        begin
            case (item.op)
                tle_pkg::OP_FINISH:
                begin
                    cursor_x_next = org_x_cur;
                    cursor_y_next = org_y_cur;
                    line_ext_next = '0;
                    ext_w_next    = '0;
                    ext_h_next    = '0;
                    halted_next   = 1'b0;
                end
                tle_pkg::OP_GLYPH:
                begin
                    if (!halted_reg)
                    begin
                        if (over)
                        begin
                            // Keep the wrap, drop the glyph, stop layout
                            cursor_x_next = vert ? lin1 : adv1;
                            cursor_y_next = vert ? adv1 : lin1;
                            line_ext_next = le1;
                            halted_next   = 1'b1;
                        end
                        else
                        begin
                            cursor_x_next = vert ? lin1 : adv2;
                            cursor_y_next = vert ? adv2 : lin1;
                            line_ext_next = le2;
                            ext_w_next    = tle_pkg::grow_extent(ext_w_reg, reach_w);
                            ext_h_next    = tle_pkg::grow_extent(ext_h_reg, reach_h);
                        end
                    end
                end
                tle_pkg::OP_LF:
                begin
                    if (!halted_reg)
                    begin
                        if (vert)
                            cursor_x_next = lf_lin;
                        else
                            cursor_y_next = lf_lin;
                        line_ext_next = '0;
                    end
                end
                tle_pkg::OP_CR:
                begin
                    if (!halted_reg)
                    begin
                        if (vert)
                            cursor_y_next = cr_adv;
                        else
                            cursor_x_next = cr_adv;
                    end
                end
                default: ;
            endcase
        end

        if (cfg.load_x)
            cursor_x_next = load_cur;
        if (cfg.load_y)
            cursor_y_next = load_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            line_ext_reg <= '0;
            ext_w_reg    <= '0;
            ext_h_reg    <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            line_ext_reg <= line_ext_next;
            ext_w_reg    <= ext_w_next;
            ext_h_reg    <= ext_h_next;
            halted_reg   <= halted_next;
        end
    end

    assign result.est_width  = ext_w_reg;
    assign result.est_height = ext_h_reg;
    assign result.stopped    = halted_reg;

`ifndef SYNTHESIS
    // A halted layout ignores every item but finish; origin writes still reload the cursors
    a_halt_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg && step && (item.op != tle_pkg::OP_FINISH)
            && !cfg.load_x && !cfg.load_y
        |=> $stable(cursor_x_reg) && $stable(cursor_y_reg) && $stable(ext_w_reg)
            && halted_reg)
        else $error("halted layout changed state");

    // Finish clears the bounding box and the halt flag
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && (item.op == tle_pkg::OP_FINISH)
        |=> (ext_w_reg == '0) && (ext_h_reg == '0) && !halted_reg && (line_ext_reg == '0))
        else $error("finish did not clear layout state");

    // Extents never shrink except on finish
    a_extent_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && (item.op == tle_pkg::OP_FINISH))
        |=> (ext_w_reg >= $past(ext_w_reg)) && (ext_h_reg >= $past(ext_h_reg)))
        else $error("extent shrank without finish");
`endif

endmodule

[rtl/text_layout_extent_estimator_top.sv]
// Top level of the text layout extent estimator: input register, result register.
// Depends on tle_pkg, tle_cfg and tle_core.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  item      | item_valid / item_ready    | op, glyph_width, glyph_height
//  result    | result_valid / result_ready| est_width, est_height, stopped
//  config    | cfg_we (no wait)           | cfg_index, cfg_data
//
// One transaction per cycle unless a finish is stalled; each taken item waits in the input register until processed.
// A finish item's result is loaded into the result register when the finish is processed and is offered from there.
// The only stall is a finish item meeting a full result register that is not drained.
// rst_n clears the handshake state, the layout state and the configuration registers.
module text_layout_extent_estimator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [1:0]                        op,
    input  logic [7:0]                        glyph_width,
    input  logic [7:0]                        glyph_height,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [15:0]                       est_width,
    output logic [15:0]                       est_height,
    output logic                              stopped,
    input  logic                              cfg_we,
    input  logic [tle_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tle_pkg::COORD_BITS-1:0]    cfg_data
);

    tle_pkg::cfg_t     cfg;
    tle_pkg::item_t    item_reg;
    tle_pkg::result_t  core_result;
    tle_pkg::result_t  result_reg;
    logic              item_valid_reg, item_valid_next;
    logic              result_valid_reg, result_valid_next;
    logic              out_free, step, take_in, is_finish;

    tle_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tle_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .item   (item_reg),
        .result (core_result)
    );

    // Only a finish needs room in the result register
    always_comb
    begin
        out_free   = !result_valid_reg || result_ready;
        is_finish  = (item_reg.op == tle_pkg::OP_FINISH);
        step       = item_valid_reg && (!is_finish || out_free);
        item_ready = !item_valid_reg || step;
        take_in    = item_valid && item_ready;

        item_valid_next = take_in ? 1'b1 : (step ? 1'b0 : item_valid_reg);

        if (step && is_finish)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers: the item loads on capture, the result on a processed finish; both hold otherwise
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.op <= op;
            item_reg.w  <= glyph_width[tle_pkg::GLYPH_BITS-1:0];
            item_reg.h  <= glyph_height[tle_pkg::GLYPH_BITS-1:0];
        end
        if (step && is_finish)
            result_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign est_width    = result_reg.est_width;
    assign est_height   = result_reg.est_height;
    assign stopped      = result_reg.stopped;

`ifndef SYNTHESIS
    // A processed finish always lands in the result register
    a_finish_reports: assert property (@(posedge clk) disable iff (!rst_n)
        step && is_finish |=> result_valid_reg)
        else $error("finish processed without a result");

    // A waiting result is never overwritten by the next finish
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_ready |-> !(step && is_finish))
        else $error("result register overwritten while full");

    // Empty input register always takes a transaction
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> item_ready)
        else $error("input stage empty but not ready");
`endif

endmodule
